[rtl/core/tta_pkg.sv]
// ----------------------------------------------------------------------------
// Temperature alarm package
// Zone, event and blink pattern codes, register map and the per-item result
// record that the temperature alarm blocks share.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int CFG_ADDR_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = 32;

    typedef logic [3:0] tta_zone_t;
    typedef logic [2:0] tta_event_t;
    typedef logic [1:0] tta_pattern_t;
    typedef logic [1:0] tta_reg_index_t;

    localparam tta_zone_t ZONE_NORMAL_1      = 4'd0;
    localparam tta_zone_t ZONE_NORMAL_2      = 4'd1;
    localparam tta_zone_t ZONE_NORMAL_3      = 4'd2;
    localparam tta_zone_t ZONE_WARN_HI_FIRST = 4'd3;
    localparam tta_zone_t ZONE_WARN_HI_RET   = 4'd4;
    localparam tta_zone_t ZONE_CRIT_HI       = 4'd5;
    localparam tta_zone_t ZONE_WARN_LO_FIRST = 4'd6;
    localparam tta_zone_t ZONE_WARN_LO_RET   = 4'd7;
    localparam tta_zone_t ZONE_CRIT_LO       = 4'd8;

    localparam tta_event_t EVENT_NONE       = 3'd0;
    localparam tta_event_t EVENT_WARN_HIGH  = 3'd1;
    localparam tta_event_t EVENT_WARN_LOW   = 3'd2;
    localparam tta_event_t EVENT_ALARM_HIGH = 3'd3;
    localparam tta_event_t EVENT_ALARM_LOW  = 3'd4;

    localparam tta_pattern_t PATTERN_OFF  = 2'd0;
    localparam tta_pattern_t PATTERN_DASH = 2'd1;
    localparam tta_pattern_t PATTERN_DOT  = 2'd2;

    localparam tta_reg_index_t REG_HIGH_CRITICAL = 2'd0;
    localparam tta_reg_index_t REG_HIGH_WARNING  = 2'd1;
    localparam tta_reg_index_t REG_LOW_WARNING   = 2'd2;
    localparam tta_reg_index_t REG_LOW_CRITICAL  = 2'd3;

    localparam int HIGH_CRITICAL_RESET = 40;
    localparam int HIGH_WARNING_RESET  = 30;
    localparam int LOW_WARNING_RESET   = 10;
    localparam int LOW_CRITICAL_RESET  = 0;

    typedef struct packed {
        tta_zone_t    zone_state;
        tta_event_t   first_event;
        tta_event_t   second_event;
        logic         led_changed;
        tta_pattern_t blink_pattern;
    } tta_step_t;

endpackage

[rtl/core/tta_in_if.sv]
// ----------------------------------------------------------------------------
// Temperature alarm input channel
// Valid/ready channel carrying one sample or return command per item.
// ----------------------------------------------------------------------------
interface tta_in_if #(
    parameter int TEMP_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [TEMP_WIDTH-1:0] temperature;

    modport source (output valid, output kind, output temperature, input ready);
    modport sink   (input valid, input kind, input temperature, output ready);
endinterface

[rtl/core/tta_out_if.sv]
// ----------------------------------------------------------------------------
// Temperature alarm output channel
// Valid/ready channel carrying the zone, events and blink pattern of an item.
// ----------------------------------------------------------------------------
interface tta_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] zone_state;
    logic [2:0] first_event;
    logic [2:0] second_event;
    logic       led_changed;
    logic [1:0] blink_pattern;

    modport source (
        output valid, output zone_state, output first_event, output second_event,
        output led_changed, output blink_pattern, input ready
    );
    modport sink (
        input valid, input zone_state, input first_event, input second_event,
        input led_changed, input blink_pattern, output ready
    );
endinterface

[rtl/core/tta_regs.sv]
// ----------------------------------------------------------------------------
// Temperature alarm threshold registers
// APB-style register file holding the four signed alarm thresholds.
// ----------------------------------------------------------------------------
module tta_regs #(
    parameter int TEMP_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tta_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
    input  logic [tta_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
    output logic [tta_pkg::CFG_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output logic signed [TEMP_WIDTH-1:0]         high_critical,
    output logic signed [TEMP_WIDTH-1:0]         high_warning,
    output logic signed [TEMP_WIDTH-1:0]         low_warning,
    output logic signed [TEMP_WIDTH-1:0]         low_critical
);
    import tta_pkg::*;

    logic signed [TEMP_WIDTH-1:0] hc_reg;
    logic signed [TEMP_WIDTH-1:0] hw_reg;
    logic signed [TEMP_WIDTH-1:0] lw_reg;
    logic signed [TEMP_WIDTH-1:0] lc_reg;
    logic                         wr_en;
    tta_reg_index_t               index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[CFG_ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= TEMP_WIDTH'(HIGH_CRITICAL_RESET);
            hw_reg <= TEMP_WIDTH'(HIGH_WARNING_RESET);
            lw_reg <= TEMP_WIDTH'(LOW_WARNING_RESET);
            lc_reg <= TEMP_WIDTH'(LOW_CRITICAL_RESET);
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_HIGH_CRITICAL: hc_reg <= pwdata[TEMP_WIDTH-1:0];
                REG_HIGH_WARNING:  hw_reg <= pwdata[TEMP_WIDTH-1:0];
                REG_LOW_WARNING:   lw_reg <= pwdata[TEMP_WIDTH-1:0];
                REG_LOW_CRITICAL:  lc_reg <= pwdata[TEMP_WIDTH-1:0];
                default:           hc_reg <= hc_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_HIGH_CRITICAL: prdata = CFG_DATA_WIDTH'(hc_reg);
            REG_HIGH_WARNING:  prdata = CFG_DATA_WIDTH'(hw_reg);
            REG_LOW_WARNING:   prdata = CFG_DATA_WIDTH'(lw_reg);
            REG_LOW_CRITICAL:  prdata = CFG_DATA_WIDTH'(lc_reg);
            default:           prdata = '0;
        endcase
    end

    assign high_critical = hc_reg;
    assign high_warning  = hw_reg;
    assign low_warning   = lw_reg;
    assign low_critical  = lc_reg;

endmodule

[rtl/core/tta_zone.sv]
// ----------------------------------------------------------------------------
// Temperature alarm zone logic
// Works out the next zone, the events raised and the blink pattern for one
// item, from a sample compared with the thresholds or from a return command.
// ----------------------------------------------------------------------------
module tta_zone #(
    parameter int TEMP_WIDTH = 16
) (
    input  tta_pkg::tta_zone_t           zone,
    input  tta_pkg::tta_pattern_t        pattern,
    input  logic                         kind,
    input  logic signed [TEMP_WIDTH-1:0] temperature,
    input  logic signed [TEMP_WIDTH-1:0] high_critical,
    input  logic signed [TEMP_WIDTH-1:0] high_warning,
    input  logic signed [TEMP_WIDTH-1:0] low_warning,
    input  logic signed [TEMP_WIDTH-1:0] low_critical,
    output tta_pkg::tta_step_t           step
);
    import tta_pkg::*;

    logic         ge_hc;
    logic         ge_hw;
    logic         le_lw;
    logic         le_lc;
    logic         hit_a;
    logic         hit_b;
    tta_event_t   ev_a;
    tta_event_t   ev_b;
    tta_zone_t    zone_a;
    tta_zone_t    zone_b;
    tta_pattern_t pat_a;
    tta_pattern_t pat_b;
    logic         ev_a_raised;

    assign ge_hc = temperature >= high_critical;
    assign ge_hw = temperature >= high_warning;
    assign le_lw = temperature <= low_warning;
    assign le_lc = temperature <= low_critical;

    // Each zone has up to two checks; the second one wins when both hit.
    always_comb
    begin
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        ev_a   = EVENT_NONE;
        ev_b   = EVENT_NONE;
        zone_a = zone;
        zone_b = zone;
        pat_a  = pattern;
        pat_b  = pattern;
        unique case (zone)
            ZONE_NORMAL_1, ZONE_NORMAL_2, ZONE_NORMAL_3:
            begin
                hit_a  = ge_hw;
                ev_a   = EVENT_WARN_HIGH;
                zone_a = ZONE_WARN_HI_FIRST;
                pat_a  = PATTERN_DASH;
                hit_b  = le_lw;
                ev_b   = EVENT_WARN_LOW;
                zone_b = ZONE_WARN_LO_FIRST;
                pat_b  = PATTERN_DASH;
            end
            ZONE_WARN_HI_FIRST:
            begin
                hit_a  = ge_hc;
                ev_a   = EVENT_ALARM_HIGH;
                zone_a = ZONE_CRIT_HI;
                pat_a  = PATTERN_DOT;
                hit_b  = !ge_hw;
                zone_b = ZONE_NORMAL_3;
                pat_b  = PATTERN_OFF;
            end
            ZONE_WARN_LO_FIRST:
            begin
                hit_a  = le_lc;
                ev_a   = EVENT_ALARM_LOW;
                zone_a = ZONE_CRIT_LO;
                pat_a  = PATTERN_DOT;
                hit_b  = !le_lw;
                zone_b = ZONE_NORMAL_2;
                pat_b  = PATTERN_OFF;
            end
            ZONE_CRIT_LO:
            begin
                hit_a  = !le_lc;
                zone_a = ZONE_WARN_LO_RET;
                pat_a  = PATTERN_DASH;
            end
            ZONE_CRIT_HI:
            begin
                hit_a  = !ge_hc;
                zone_a = ZONE_WARN_HI_RET;
                pat_a  = PATTERN_DASH;
            end
            ZONE_WARN_LO_RET:
            begin
                hit_a  = le_lc;
                zone_a = ZONE_CRIT_LO;
                pat_a  = PATTERN_DOT;
                hit_b  = !le_lw;
                zone_b = ZONE_NORMAL_2;
                pat_b  = PATTERN_OFF;
            end
            ZONE_WARN_HI_RET:
            begin
                hit_a  = !ge_hw;
                zone_a = ZONE_NORMAL_3;
                pat_a  = PATTERN_OFF;
                hit_b  = ge_hc;
                zone_b = ZONE_CRIT_HI;
                pat_b  = PATTERN_DOT;
            end
            default:
            begin
                hit_a = 1'b0;
            end
        endcase
    end

    assign ev_a_raised = hit_a && (ev_a != EVENT_NONE);

    always_comb
    begin
        step.led_changed = 1'b0;
        step.first_event  = EVENT_NONE;
        step.second_event = EVENT_NONE;
        step.zone_state   = zone;
        step.blink_pattern = pattern;
        if (kind)
        begin
            step.zone_state = ZONE_NORMAL_1;
        end
        else
        begin
            step.led_changed = hit_a || hit_b;
            if (hit_b)
            begin
                step.zone_state    = zone_b;
                step.blink_pattern = pat_b;
            end
            else if (hit_a)
            begin
                step.zone_state    = zone_a;
                step.blink_pattern = pat_a;
            end
            if (ev_a_raised)
            begin
                step.first_event  = ev_a;
                step.second_event = hit_b ? ev_b : EVENT_NONE;
            end
            else if (hit_b)
            begin
                step.first_event = ev_b;
            end
        end
    end

endmodule

[rtl/core/temp_threshold_alarm_fsm.sv]
// ----------------------------------------------------------------------------
// Temperature threshold alarm
// Nine-zone temperature alarm with hysteresis, programmable thresholds over
// an APB-style port and valid/ready item channels.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle while the output is taken, set by the single zone register update.
// The input register takes one more item while a result waits at the output.
// Reset clears the zone to the first normal state, the pattern to off and
// the thresholds to 40, 30, 10 and 0.
module temp_threshold_alarm_fsm #(
    parameter int TEMP_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tta_in_if.sink                             in_ch,
    tta_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tta_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [tta_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [tta_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                               pready
);
    import tta_pkg::*;

    logic signed [TEMP_WIDTH-1:0] high_critical;
    logic signed [TEMP_WIDTH-1:0] high_warning;
    logic signed [TEMP_WIDTH-1:0] low_warning;
    logic signed [TEMP_WIDTH-1:0] low_critical;

    logic                         in_valid_reg;
    logic                         in_kind_reg;
    logic signed [TEMP_WIDTH-1:0] in_temp_reg;
    logic                         out_valid_reg;
    tta_step_t                    result_reg;
    tta_zone_t                    zone_reg;
    tta_pattern_t                 pattern_reg;

    logic                         out_free;
    logic                         advance;
    logic                         in_take;
    tta_step_t                    step;

    tta_regs #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .high_critical (high_critical),
        .high_warning  (high_warning),
        .low_warning   (low_warning),
        .low_critical  (low_critical)
    );

    tta_zone #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_zone (
        .zone          (zone_reg),
        .pattern       (pattern_reg),
        .kind          (in_kind_reg),
        .temperature   (in_temp_reg),
        .high_critical (high_critical),
        .high_warning  (high_warning),
        .low_warning   (low_warning),
        .low_critical  (low_critical),
        .step          (step)
    );

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || out_free;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            zone_reg      <= ZONE_NORMAL_1;
            pattern_reg   <= PATTERN_OFF;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                zone_reg      <= step.zone_state;
                pattern_reg   <= step.blink_pattern;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= in_ch.kind;
            in_temp_reg <= in_ch.temperature;
        end
        if (advance)
        begin
            result_reg <= step;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.zone_state    = result_reg.zone_state;
    assign out_ch.first_event   = result_reg.first_event;
    assign out_ch.second_event  = result_reg.second_event;
    assign out_ch.led_changed   = result_reg.led_changed;
    assign out_ch.blink_pattern = result_reg.blink_pattern;

endmodule

[rtl/core/tta_checker.sv]
// ----------------------------------------------------------------------------
// Temperature alarm checker
// Port-level assertions on the result channel of the temperature alarm.
// ----------------------------------------------------------------------------
module tta_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] first_event,
    input logic [2:0] second_event,
    input logic       led_changed,
    input logic [1:0] blink_pattern
);
    import tta_pkg::*;

    tta_pattern_t last_pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pattern_reg <= PATTERN_OFF;
        end
        else if (out_valid && out_ready)
        begin
            last_pattern_reg <= blink_pattern;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result item withdrawn before it was taken.");

    a_pattern_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !led_changed |-> blink_pattern == last_pattern_reg)
        else $error("Blink pattern changed without a pattern being set.");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && second_event != EVENT_NONE |-> first_event != EVENT_NONE)
        else $error("Second event reported without a first event.");

    a_event_sets_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_event != EVENT_NONE |-> led_changed)
        else $error("Event reported without a blink pattern being set.");

endmodule

bind temp_threshold_alarm_fsm tta_checker u_tta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .first_event   (out_ch.first_event),
    .second_event  (out_ch.second_event),
    .led_changed   (out_ch.led_changed),
    .blink_pattern (out_ch.blink_pattern)
);

[test/temp_threshold_alarm_fsm_tb.sv]
// ----------------------------------------------------------------------------
// Temperature threshold alarm testbench
// Drives samples and return commands through the input channel, moves the
// four thresholds over the APB port between phases and checks every result
// against a zone predictor kept in step with each accepted item.
// ----------------------------------------------------------------------------
module temp_threshold_alarm_fsm_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tta_pkg::*;

    localparam int TW = 16;

    typedef struct packed {
        logic                 kind;
        logic signed [TW-1:0] temperature;
    } sample_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_WIDTH-1:0] paddr;
    logic [CFG_DATA_WIDTH-1:0] pwdata;
    logic [CFG_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    tta_in_if #(.TEMP_WIDTH(TW)) in_ch ();
    tta_out_if                   out_ch ();

    temp_threshold_alarm_fsm #(
        .TEMP_WIDTH(TW)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sample_t   sample_queue[$];
    tta_step_t step_queue[$];
    int        failures = 0;

    bit in_busy   = 0;
    bit in_taken  = 0;
    bit in_burst  = 0;
    int in_gap    = 0;
    bit out_taken = 0;
    bit out_burst = 0;
    int out_stall = 0;

    tta_zone_t            zone_q    = ZONE_NORMAL_1;
    tta_pattern_t         pattern_q = PATTERN_OFF;
    logic signed [TW-1:0] hc_q      = TW'(HIGH_CRITICAL_RESET);
    logic signed [TW-1:0] hw_q      = TW'(HIGH_WARNING_RESET);
    logic signed [TW-1:0] lw_q      = TW'(LOW_WARNING_RESET);
    logic signed [TW-1:0] lc_q      = TW'(LOW_CRITICAL_RESET);

    int           ev_count;
    tta_event_t   ev_first;
    tta_event_t   ev_second;
    bit           led_set;

    function automatic void raise_event(input tta_event_t ev);
        if (ev_count == 0)
        begin
            ev_first = ev;
        end
        else if (ev_count == 1)
        begin
            ev_second = ev;
        end
        if (ev_count < 2)
        begin
            ev_count++;
        end
    endfunction

    function automatic void enter_zone(input tta_zone_t z, input tta_pattern_t p);
        zone_q    = z;
        pattern_q = p;
        led_set   = 1'b1;
    endfunction

    function automatic tta_step_t advance_zone(input logic kind,
                                               input logic signed [TW-1:0] t);
        tta_step_t r;
        ev_count  = 0;
        ev_first  = EVENT_NONE;
        ev_second = EVENT_NONE;
        led_set   = 1'b0;
        if (kind)
        begin
            zone_q = ZONE_NORMAL_1;
        end
        else
        begin
            case (zone_q)
                ZONE_NORMAL_1, ZONE_NORMAL_2, ZONE_NORMAL_3:
                begin
                    if (t >= hw_q)
                    begin
                        raise_event(EVENT_WARN_HIGH);
                        enter_zone(ZONE_WARN_HI_FIRST, PATTERN_DASH);
                    end
                    if (t <= lw_q)
                    begin
                        raise_event(EVENT_WARN_LOW);
                        enter_zone(ZONE_WARN_LO_FIRST, PATTERN_DASH);
                    end
                end
                ZONE_WARN_HI_FIRST:
                begin
                    if (t >= hc_q)
                    begin
                        raise_event(EVENT_ALARM_HIGH);
                        enter_zone(ZONE_CRIT_HI, PATTERN_DOT);
                    end
                    if (t < hw_q)
                    begin
                        enter_zone(ZONE_NORMAL_3, PATTERN_OFF);
                    end
                end
                ZONE_WARN_LO_FIRST:
                begin
                    if (t <= lc_q)
                    begin
                        raise_event(EVENT_ALARM_LOW);
                        enter_zone(ZONE_CRIT_LO, PATTERN_DOT);
                    end
                    if (t > lw_q)
                    begin
                        enter_zone(ZONE_NORMAL_2, PATTERN_OFF);
                    end
                end
                ZONE_CRIT_LO:
                begin
                    if (t > lc_q)
                    begin
                        enter_zone(ZONE_WARN_LO_RET, PATTERN_DASH);
                    end
                end
                ZONE_CRIT_HI:
                begin
                    if (t < hc_q)
                    begin
                        enter_zone(ZONE_WARN_HI_RET, PATTERN_DASH);
                    end
                end
                ZONE_WARN_LO_RET:
                begin
                    if (t <= lc_q)
                    begin
                        enter_zone(ZONE_CRIT_LO, PATTERN_DOT);
                    end
                    if (t > lw_q)
                    begin
                        enter_zone(ZONE_NORMAL_2, PATTERN_OFF);
                    end
                end
                ZONE_WARN_HI_RET:
                begin
                    if (t < hw_q)
                    begin
                        enter_zone(ZONE_NORMAL_3, PATTERN_OFF);
                    end
                    if (t >= hc_q)
                    begin
                        enter_zone(ZONE_CRIT_HI, PATTERN_DOT);
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.zone_state    = zone_q;
        r.first_event   = ev_first;
        r.second_event  = ev_second;
        r.led_changed   = led_set;
        r.blink_pattern = pattern_q;
        return r;
    endfunction

    function automatic int draw_wait(input bit burst);
        if (burst)
        begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    function automatic logic [TW-1:0] pick_temperature();
        int sel;
        int off;
        logic [TW-1:0] base;
        sel = $urandom_range(0, 9);
        off = $urandom_range(0, 4);
        off = off - 2;
        case ($urandom_range(0, 3))
            0: base = hc_q;
            1: base = hw_q;
            2: base = lw_q;
            default: base = lc_q;
        endcase
        if (sel == 0)
        begin
            return TW'($urandom);
        end
        if (sel == 1)
        begin
            return 16'h7FFF;
        end
        if (sel == 2)
        begin
            return 16'h8000;
        end
        return TW'(base + off);
    endfunction

    task automatic push_sample(input bit kind, input int t);
        sample_t s;
        s.kind        = kind;
        s.temperature = t[TW-1:0];
        sample_queue.push_back(s);
    endtask

    task automatic apb_write(input tta_reg_index_t idx, input int value);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value[15:0]};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HIGH_CRITICAL: hc_q = value[TW-1:0];
            REG_HIGH_WARNING:  hw_q = value[TW-1:0];
            REG_LOW_WARNING:   lw_q = value[TW-1:0];
            default:           lc_q = value[TW-1:0];
        endcase
    endtask

    task automatic set_thresholds(input int hc, input int hw, input int lw, input int lc);
        apb_write(REG_HIGH_CRITICAL, hc);
        apb_write(REG_HIGH_WARNING, hw);
        apb_write(REG_LOW_WARNING, lw);
        apb_write(REG_LOW_CRITICAL, lc);
    endtask

    task automatic wait_idle();
        while (sample_queue.size() != 0 || in_busy || step_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic configure_phase(input int k);
        int base;
        int spread;
        int v;
        case (k)
            0, 1:
            begin
                spread = (k == 0) ? 5 : 16383;
                base = (k == 0) ? int'($urandom_range(0, 200)) - 100
                                : int'($urandom_range(0, 16383)) - 32768;
                v = base + int'($urandom_range(0, spread));
                set_thresholds(v + int'($urandom_range(0, spread)) * 2
                                 + int'($urandom_range(0, spread)),
                               v + int'($urandom_range(0, spread)),
                               v, base);
            end
            2: set_thresholds($urandom, $urandom, $urandom, $urandom);
            3: set_thresholds(32767, 32767, -32768, -32768);
            4: set_thresholds(-32768, -32768, 32767, 32767);
            5:
            begin
                v = $urandom;
                set_thresholds(v, v, v, v);
            end
            default: set_thresholds(-32768, 32767, -32768, 32767);
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin : check_steps
        tta_step_t got;
        tta_step_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                step_queue.push_back(advance_zone(in_ch.kind, in_ch.temperature));
                in_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_taken         = 1'b1;
                got.zone_state    = out_ch.zone_state;
                got.first_event   = out_ch.first_event;
                got.second_event  = out_ch.second_event;
                got.led_changed   = out_ch.led_changed;
                got.blink_pattern = out_ch.blink_pattern;
                if (step_queue.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, got);
                    failures++;
                end
                else
                begin
                    want = step_queue.pop_front();
                    check_field("zone_state", want.zone_state, got.zone_state);
                    check_field("first_event", want.first_event, got.first_event);
                    check_field("second_event", want.second_event, got.second_event);
                    check_field("led_changed", want.led_changed, got.led_changed);
                    check_field("blink_pattern", want.blink_pattern, got.blink_pattern);
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_samples
        sample_t next_item;
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                in_busy  = 1'b0;
            end
            if (!in_busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end
                else if (sample_queue.size() > 0)
                begin
                    next_item = sample_queue.pop_front();
                    in_busy   = 1'b1;
                    in_ch.kind        <= next_item.kind;
                    in_ch.temperature <= next_item.temperature;
                    if ($urandom_range(0, 19) == 0)
                    begin
                        in_burst = !in_burst;
                    end
                    in_gap = draw_wait(in_burst);
                end
            end
            in_ch.valid <= in_busy;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if ($urandom_range(0, 19) == 0)
                begin
                    out_burst = !out_burst;
                end
                out_stall = draw_wait(out_burst);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("** temp_threshold_alarm_fsm: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int i;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = 1'b0;
        in_ch.temperature = '0;
        out_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the zones at the reset thresholds, including re-entry into
        // critical from the return warning states, which raises no alarm.
        push_sample(1, -32768);
        push_sample(0, 20);
        push_sample(0, 30);
        push_sample(0, 40);
        push_sample(0, 39);
        push_sample(0, 40);
        push_sample(0, 32767);
        push_sample(0, 35);
        push_sample(0, 29);
        push_sample(0, 10);
        push_sample(0, 11);
        push_sample(0, 5);
        push_sample(0, 0);
        push_sample(0, -32768);
        push_sample(0, 1);
        push_sample(0, 0);
        push_sample(0, 5);
        push_sample(0, 11);
        push_sample(0, 30);
        push_sample(0, 29);
        push_sample(0, 30);
        push_sample(1, -1);
        push_sample(0, -32768);
        wait_idle();

        // Overlapping thresholds, so that both checks of a zone hit at once.
        set_thresholds(-32768, -32768, 32767, 32767);
        push_sample(1, 32767);
        push_sample(0, 0);
        push_sample(0, 0);
        wait_idle();

        for (p = 0; p < 8; p++)
        begin
            configure_phase(p % 7);
            for (i = 0; i < 90; i++)
            begin
                push_sample($urandom_range(0, 19) == 0, int'(pick_temperature()));
            end
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (failures == 0)
        begin
            $display("** temp_threshold_alarm_fsm: PASSED **");
        end
        else
        begin
            $display("** temp_threshold_alarm_fsm: FAILED **");
        end
        $finish;
    end

endmodule
